// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`endif

// ===== rtl/baro_pkg.sv =====
package baro_pkg;
    localparam int DIV_W = 32;
    localparam logic [31:0] C_B6_OFS = 32'd4000;
    localparam logic [31:0] C_HALF = 32'd32768;
    localparam logic [31:0] C_B7_BASE = 32'd50000;
    localparam logic [31:0] C_P1 = 32'd3038;
    localparam logic [31:0] C_P2 = 32'hFFFF_E343;
    localparam logic [31:0] C_P3 = 32'd3791;

    typedef logic [31:0] t_word;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_CAL_A    = 3'd0,
        REG_CAL_B    = 3'd1,
        REG_CAL_QUAD = 3'd2,
        REG_CAL_M    = 3'd3,
        REG_OSS      = 3'd4
    } t_reg_idx;

    // Calibration set; the user must hold it fixed while the pipeline runs.
    typedef struct packed {
        t_word ac1;
        t_word ac2;
        t_word ac3;
        t_word ac4;
        t_word ac5;
        t_word ac6;
        t_word b1;
        t_word b2;
        t_word mc;
        t_word md;
        logic [1:0] oss;
    } t_cal;

    // Arithmetic shift right of a 32-bit word.
    function automatic t_word asr(input t_word v, input int n);
        asr = t_word'($signed(v) >>> n);
    endfunction
endpackage

// ===== rtl/barometric_compensation_top.sv =====
// Path: stages 1-3, temperature divider, stages 4-9, pressure divider, 10-12.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The two 32-stage dividers set the latency; no stage chains two multiplies.
// Reset is synchronous, active low, clears valid bits and calibration registers.
// The receiver cannot stall: each result is shown for exactly one cycle.
module barometric_compensation_top
    import baro_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  logic [15:0] i_raw_temp,
    input  logic [23:0] i_raw_pres_bytes,
    output logic        o_valid,
    output logic signed [31:0] o_temp_tenths_c,
    output logic signed [31:0] o_pressure_pa,
    output logic        o_div_error
);
    logic [47:0] r_cal_a, r_cal_b, r_cal_m;
    logic [31:0] r_cal_q;
    logic [1:0]  r_oss;
    t_cal        w_cal;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_q <= '0;
            r_cal_m <= '0;
            r_oss   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CAL_A:    r_cal_a <= i_cfg_data;
                REG_CAL_B:    r_cal_b <= i_cfg_data;
                REG_CAL_QUAD: r_cal_q <= i_cfg_data[31:0];
                REG_CAL_M:    r_cal_m <= i_cfg_data;
                REG_OSS:      r_oss   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Unpack coefficients to 32-bit words.
    always_comb begin
        w_cal.ac1 = t_word'($signed(r_cal_a[47:32]));
        w_cal.ac2 = t_word'($signed(r_cal_a[31:16]));
        w_cal.ac3 = t_word'($signed(r_cal_a[15:0]));
        w_cal.ac4 = {16'd0, r_cal_b[47:32]};
        w_cal.ac5 = {16'd0, r_cal_b[31:16]};
        w_cal.ac6 = {16'd0, r_cal_b[15:0]};
        w_cal.b1  = t_word'($signed(r_cal_q[31:16]));
        w_cal.b2  = t_word'($signed(r_cal_q[15:0]));
        w_cal.mc  = t_word'($signed(r_cal_m[31:16]));
        w_cal.md  = t_word'($signed(r_cal_m[15:0]));
        w_cal.oss = r_oss;
    end

    assign busy = 1'b0;
    logic w_acc;
    assign w_acc = start && !busy;

    // Stage 1: raw pressure shift, ut - ac6.
    logic  r1_v;
    t_word r1_d, r1_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else r1_v <= w_acc;
        r1_d  <= {16'd0, i_raw_temp} - w_cal.ac6;
        r1_up <= {8'd0, i_raw_pres_bytes} >> (4'd8 - {2'd0, w_cal.oss});
    end

    // Stage 2: multiply by ac5.
    logic  r2_v;
    t_word r2_m, r2_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else r2_v <= r1_v;
        r2_m  <= r1_d * w_cal.ac5;
        r2_up <= r1_up;
    end

    // Stage 3: x1 and temperature divisor.
    logic  r3_v;
    t_word r3_x1, r3_den, r3_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else r3_v <= r2_v;
        r3_x1  <= asr(r2_m, 15);
        r3_den <= asr(r2_m, 15) + w_cal.md;
        r3_up  <= r2_up;
    end

    // Signed divide (mc << 11) / den via magnitudes.
    t_word w_tnum, w_tnum_mag, w_tden_mag;
    logic  w_tneg;
    assign w_tnum     = w_cal.mc << 11;
    assign w_tnum_mag = w_tnum[31] ? -w_tnum : w_tnum;
    assign w_tden_mag = r3_den[31] ? -r3_den : r3_den;
    assign w_tneg     = w_tnum[31] ^ r3_den[31];

    localparam int TSB = 32 + 32 + 2;
    logic            w_td_v;
    t_word           w_td_q;
    logic [TSB-1:0]  w_td_sb;
    baro_div #(.SB_W(TSB)) u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_v),
        .i_num   (w_tnum_mag),
        .i_den   (w_tden_mag),
        .i_sb    ({r3_x1, r3_up, w_tneg, r3_den == '0}),
        .o_valid (w_td_v),
        .o_quo   (w_td_q),
        .o_sb    (w_td_sb)
    );

    // Stage 4: b5, temperature, b6.
    logic  r4_v, r4_err;
    t_word r4_temp, r4_b6, r4_up;
    t_word w_x2, w_b5;
    assign w_x2 = w_td_sb[1] ? -w_td_q : w_td_q;
    assign w_b5 = w_td_sb[TSB-1 -: 32] + w_x2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else r4_v <= w_td_v;
        r4_err  <= w_td_sb[0];
        r4_temp <= asr(w_b5 + 32'd8, 4);
        r4_b6   <= w_b5 - C_B6_OFS;
        r4_up   <= w_td_sb[33:2];
    end

    // Stage 5: b6 square and linear products.
    logic  r5_v, r5_err;
    t_word r5_sq, r5_a2, r5_a3, r5_temp, r5_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else r5_v <= r4_v;
        r5_err  <= r4_err;
        r5_sq   <= r4_b6 * r4_b6;
        r5_a2   <= w_cal.ac2 * r4_b6;
        r5_a3   <= w_cal.ac3 * r4_b6;
        r5_temp <= r4_temp;
        r5_up   <= r4_up;
    end

    // Stage 6: quadratic products with b1 and b2.
    logic  r6_v, r6_err;
    t_word r6_q2, r6_q1, r6_a2, r6_a3, r6_temp, r6_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else r6_v <= r5_v;
        r6_err  <= r5_err;
        r6_q2   <= w_cal.b2 * asr(r5_sq, 12);
        r6_q1   <= w_cal.b1 * asr(r5_sq, 12);
        r6_a2   <= asr(r5_a2, 11);
        r6_a3   <= asr(r5_a3, 13);
        r6_temp <= r5_temp;
        r6_up   <= r5_up;
    end

    // Stage 7: b3 and x3 for b4.
    logic  r7_v, r7_err;
    t_word r7_b3, r7_x3, r7_temp, r7_up;
    t_word w_x3a;
    assign w_x3a = asr(r6_q2, 11) + r6_a2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else r7_v <= r6_v;
        r7_err  <= r6_err;
        r7_b3   <= asr(((w_cal.ac1 << 2) + w_x3a << w_cal.oss) + 32'd2, 2);
        r7_x3   <= asr(r6_a3 + asr(r6_q1, 16) + 32'd2, 2);
        r7_temp <= r6_temp;
        r7_up   <= r6_up;
    end

    // Stage 8: ac4 product and up - b3.
    logic  r8_v, r8_err;
    t_word r8_b4m, r8_d, r8_temp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_v <= 1'b0;
        else r8_v <= r7_v;
        r8_err  <= r7_err;
        r8_b4m  <= w_cal.ac4 * (r7_x3 + C_HALF);
        r8_d    <= r7_up - r7_b3;
        r8_temp <= r7_temp;
    end

    // Stage 9: b4, its zero check, and b7.
    logic  r9_v, r9_err;
    t_word r9_b4, r9_b7, r9_temp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r9_v <= 1'b0;
        else r9_v <= r8_v;
        r9_err  <= r8_err || (r8_b4m >> 15) == '0;
        r9_b4   <= r8_b4m >> 15;
        r9_b7   <= r8_d * (C_B7_BASE >> w_cal.oss);
        r9_temp <= r8_temp;
    end

    // Unsigned pressure divide; the doubling happens before or after.
    logic            w_hi;
    t_word           w_pnum, w_pden;
    assign w_hi   = r9_b7[31];
    assign w_pnum = w_hi ? r9_b7 : (r9_b7 << 1);
    assign w_pden = r9_err ? 32'd1 : r9_b4;

    localparam int PSB = 32 + 2;
    logic           w_pd_v;
    t_word          w_pd_q;
    logic [PSB-1:0] w_pd_sb;
    baro_div #(.SB_W(PSB)) u_pdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r9_v),
        .i_num   (w_pnum),
        .i_den   (w_pden),
        .i_sb    ({r9_temp, w_hi, r9_err}),
        .o_valid (w_pd_v),
        .o_quo   (w_pd_q),
        .o_sb    (w_pd_sb)
    );

    // Stage 10: p and the products of the final correction.
    logic  r10_v, r10_err;
    t_word r10_p, r10_pp, r10_x2, r10_temp;
    t_word w_p;
    assign w_p = w_pd_sb[1] ? (w_pd_q << 1) : w_pd_q;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r10_v <= 1'b0;
        else r10_v <= w_pd_v;
        r10_err  <= w_pd_sb[0];
        r10_p    <= w_p;
        r10_pp   <= asr(w_p, 8) * asr(w_p, 8);
        r10_x2   <= asr(C_P2 * w_p, 16);
        r10_temp <= w_pd_sb[PSB-1 -: 32];
    end

    // Stage 11: times 3038.
    logic  r11_v, r11_err;
    t_word r11_x1, r11_p, r11_x2, r11_temp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r11_v <= 1'b0;
        else r11_v <= r10_v;
        r11_err  <= r10_err;
        r11_x1   <= asr(r10_pp * C_P1, 16);
        r11_p    <= r10_p;
        r11_x2   <= r10_x2;
        r11_temp <= r10_temp;
    end

    // Stage 12: final correction and output register, zeroed on error.
    logic  r12_v, r12_err;
    t_word r12_p, r12_temp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r12_v <= 1'b0;
        else r12_v <= r11_v;
        r12_err  <= r11_err;
        r12_p    <= r11_err ? '0 : r11_p + asr(r11_x1 + r11_x2 + C_P3, 4);
        r12_temp <= r11_err ? '0 : r11_temp;
    end

    assign o_valid         = r12_v;
    assign o_temp_tenths_c = $signed(r12_temp);
    assign o_pressure_pa   = $signed(r12_p);
    assign o_div_error     = r12_err;
endmodule

// ===== rtl/baro_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Sideband payload travels alongside each item.
module baro_div
    import baro_pkg::*;
#(
    parameter int SB_W = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  t_word           i_num,
    input  t_word           i_den,
    input  logic [SB_W-1:0] i_sb,
    output logic            o_valid,
    output t_word           o_quo,
    output logic [SB_W-1:0] o_sb
);
    logic [DIV_W-1:0]  r_vld;
    t_word             r_rem [DIV_W];
    t_word             r_num [DIV_W];
    t_word             r_den [DIV_W];
    t_word             r_quo [DIV_W];
    logic [SB_W-1:0]   r_sb  [DIV_W];

    // Valid bits are the only control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DIV_W-2:0], i_valid};
        end
    end

    // Each stage retires one quotient bit, MSB first.
    for (genvar s = 0; s < DIV_W; s++) begin : g_st
        logic [32:0] w_trial;
        t_word       w_rin;
        t_word       w_nin;
        t_word       w_din;
        t_word       w_qin;
        logic [SB_W-1:0] w_sin;
        if (s == 0) begin : g_first
            assign w_rin = '0;
            assign w_nin = i_num;
            assign w_din = i_den;
            assign w_qin = '0;
            assign w_sin = i_sb;
        end else begin : g_rest
            assign w_rin = r_rem[s-1];
            assign w_nin = r_num[s-1];
            assign w_din = r_den[s-1];
            assign w_qin = r_quo[s-1];
            assign w_sin = r_sb[s-1];
        end
        assign w_trial = {w_rin, w_nin[31]} - {1'b0, w_din};
        always_ff @(posedge i_clk) begin
            r_num[s] <= {w_nin[30:0], 1'b0};
            r_den[s] <= w_din;
            r_sb[s]  <= w_sin;
            if (!w_trial[32]) begin
                r_rem[s] <= w_trial[31:0];
                r_quo[s] <= {w_qin[30:0], 1'b1};
            end else begin
                r_rem[s] <= {w_rin[30:0], w_nin[31]};
                r_quo[s] <= {w_qin[30:0], 1'b0};
            end
        end
    end

    assign o_valid = r_vld[DIV_W-1];
    assign o_quo   = r_quo[DIV_W-1];
    assign o_sb    = r_sb[DIV_W-1];
endmodule

// ===== rtl/baro_checker.sv =====
`include "assert_macros.svh"
// Port-level checks of the compensation block.
module baro_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic signed [31:0] o_temp_tenths_c,
    input logic signed [31:0] o_pressure_pa,
    input logic        o_div_error
);
    // An error result carries zero values.
    `ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_valid && o_div_error,
        o_temp_tenths_c == 0 && o_pressure_pa == 0, "error result not zero")
    // The pipeline never refuses work.
    `ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !busy, "busy raised")
    // No result comes right after reset without a transfer far enough back.
    `ASSERT_NEXT(a_rst_quiet, i_clk, 1'b1, !i_rst_n, !o_valid, "result after reset")
endmodule

bind barometric_compensation_top baro_checker u_baro_checker (.*);

// ===== verif/barometric_compensation_top_tb.sv =====
`timescale 1ns / 1ps

module barometric_compensation_top_tb
    import baro_pkg::*;
();

    typedef enum logic {ROW_CFG, ROW_SAMPLE} t_row_kind;

    typedef struct {
        logic signed [31:0] temp;
        logic signed [31:0] pres;
        logic               err;
    } t_reading;

    typedef struct {
        t_row_kind   kind;
        t_reg_idx    idx;
        logic [47:0] data;
        logic [15:0] raw_temp;
        logic [23:0] raw_pres;
        bit          typed;
        t_reading    want;
    } t_stim_row;

    localparam int LATENCY     = 76;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 215;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [47:0] i_cfg_data;
    logic [15:0] i_raw_temp;
    logic [23:0] i_raw_pres_bytes;
    logic        o_valid;
    logic signed [31:0] o_temp_tenths_c;
    logic signed [31:0] o_pressure_pa;
    logic        o_div_error;

    // Local copy of the calibration registers.
    logic [47:0] cal_a, cal_b, cal_m;
    logic [31:0] cal_quad;
    logic [1:0]  oss_set;

    t_reading  pending_readings[$];
    t_stim_row directed_rows[$];
    int        fail_count;
    int        items_sent;
    int        readings_seen;
    int        error_readings;
    int        cycle_count;
    int        idle_pct;

    barometric_compensation_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_raw_temp      (i_raw_temp),
        .i_raw_pres_bytes(i_raw_pres_bytes),
        .o_valid         (o_valid),
        .o_temp_tenths_c (o_temp_tenths_c),
        .o_pressure_pa   (o_pressure_pa),
        .o_div_error     (o_div_error)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_word sext16(input logic [15:0] v);
        sext16 = {{16{v[15]}}, v};
    endfunction

    function automatic t_word shr_arith(input t_word v, input int n);
        shr_arith = t_word'($signed(v) >>> n);
    endfunction

    // Signed division truncating toward zero, wrapping on overflow.
    function automatic t_word div_signed(input t_word a, input t_word b);
        t_word ua, ub, q;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q = ua / ub;
        div_signed = (a[31] != b[31]) ? -q : q;
    endfunction

    // Integer temperature and pressure compensation for one sample pair.
    function automatic t_reading compensate(input logic [15:0] raw_t, input logic [23:0] raw_p);
        t_word ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        t_word ut, up, x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p;
        int oss;
        t_reading r;
        ac1 = sext16(cal_a[47:32]);
        ac2 = sext16(cal_a[31:16]);
        ac3 = sext16(cal_a[15:0]);
        ac4 = {16'd0, cal_b[47:32]};
        ac5 = {16'd0, cal_b[31:16]};
        ac6 = {16'd0, cal_b[15:0]};
        b1 = sext16(cal_quad[31:16]);
        b2 = sext16(cal_quad[15:0]);
        mc = sext16(cal_m[31:16]);
        md = sext16(cal_m[15:0]);
        oss = int'(oss_set);
        ut = {16'd0, raw_t};
        up = {8'd0, raw_p} >> (8 - oss);
        r.temp = '0;
        r.pres = '0;
        r.err = 1'b1;

        // Temperature.
        x1 = shr_arith((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == '0) begin
            return r;
        end
        x2 = div_signed(mc << 11, den);
        b5 = x1 + x2;
        r.temp = shr_arith(b5 + 32'd8, 4);

        // Pressure scale terms.
        b6 = b5 - C_B6_OFS;
        sq = shr_arith(b6 * b6, 12);
        x1 = shr_arith(b2 * sq, 11);
        x2 = shr_arith(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = shr_arith(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
        x1 = shr_arith(ac3 * b6, 13);
        x2 = shr_arith(b1 * sq, 16);
        x3 = shr_arith(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + C_HALF)) >> 15;
        if (b4 == '0) begin
            r.temp = '0;
            return r;
        end

        // Pressure quotient and final correction.
        b7 = (up - b3) * (C_B7_BASE >> oss);
        if (!b7[31]) begin
            p = (b7 << 1) / b4;
        end else begin
            p = (b7 / b4) << 1;
        end
        x1 = shr_arith(p, 8) * shr_arith(p, 8);
        x1 = shr_arith(x1 * C_P1, 16);
        x2 = shr_arith(C_P2 * p, 16);
        p = p + shr_arith(x1 + x2 + C_P3, 4);
        r.pres = p;
        r.err = 1'b0;
        return r;
    endfunction

    // Register write with the write enable dropped after it; only issued while the pipeline is empty.
    task automatic write_reg(input t_reg_idx idx, input logic [47:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_CAL_A:    cal_a = data;
            REG_CAL_B:    cal_b = data;
            REG_CAL_QUAD: cal_quad = data[31:0];
            REG_CAL_M:    cal_m = data;
            REG_OSS:      oss_set = data[1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Wait for the pipeline to drain before touching the registers.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Present one sample pair and hold it until the transfer happens.
    task automatic send_sample(input logic [15:0] raw_t, input logic [23:0] raw_p,
                               input bit typed, input t_reading want);
        int gap;
        start <= 1'b1;
        i_raw_temp <= raw_t;
        i_raw_pres_bytes <= raw_p;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        pending_readings.push_back(typed ? want : compensate(raw_t, raw_p));
        items_sent++;
        @(posedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic add_cfg(input t_reg_idx idx, input logic [47:0] data);
        t_stim_row row;
        row = '{kind: ROW_CFG, idx: idx, data: data, raw_temp: '0, raw_pres: '0,
                typed: 1'b0, want: '{temp: '0, pres: '0, err: 1'b0}};
        directed_rows.push_back(row);
    endtask

    task automatic add_sample(input logic [15:0] raw_t, input logic [23:0] raw_p,
                              input bit typed, input int t, input int p, input bit e);
        t_stim_row row;
        row = '{kind: ROW_SAMPLE, idx: REG_CAL_A, data: '0, raw_temp: raw_t, raw_pres: raw_p,
                typed: typed, want: '{temp: t, pres: p, err: e}};
        directed_rows.push_back(row);
    endtask

    function automatic logic [47:0] rand48();
        rand48 = {$urandom(), $urandom()};
    endfunction

    // Calibration near the usual factory values, or fully random, or an extreme.
    task automatic load_calibration(input int phase);
        int mode;
        mode = $urandom_range(2);
        if (phase == 2) begin
            write_reg(REG_CAL_A, '1);
            write_reg(REG_CAL_B, '1);
            write_reg(REG_CAL_QUAD, '1);
            write_reg(REG_CAL_M, '1);
        end else if (phase == 5) begin
            write_reg(REG_CAL_A, 48'h7FFF_8000_7FFF);
            write_reg(REG_CAL_B, 48'hFFFF_0001_0000);
            write_reg(REG_CAL_QUAD, 32'h8000_7FFF);
            write_reg(REG_CAL_M, 48'h8000_8000_7FFF);
        end else if (mode == 0) begin
            write_reg(REG_CAL_A, rand48());
            write_reg(REG_CAL_B, rand48());
            write_reg(REG_CAL_QUAD, {16'd0, $urandom()});
            write_reg(REG_CAL_M, rand48());
        end else begin
            write_reg(REG_CAL_A, {16'(408 + $urandom_range(200) - 100),
                                  16'(-72 + $urandom_range(100) - 50),
                                  16'(-14383 + $urandom_range(400) - 200)});
            write_reg(REG_CAL_B, {16'(32741 - $urandom_range(300)),
                                  16'(32757 - $urandom_range(300)),
                                  16'(23153 + $urandom_range(400) - 200)});
            write_reg(REG_CAL_QUAD, {16'(6190 + $urandom_range(100)), 16'($urandom_range(8))});
            write_reg(REG_CAL_M, {16'h8000, 16'(-8711 + $urandom_range(200) - 100),
                                  16'(2868 + $urandom_range(200) - 100)});
        end
        write_reg(REG_OSS, 48'(phase % 4));
    endtask

    // Result checking against the oldest expectation.
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_readings.size() == 0) begin
                $error("unexpected reading: temp %0d pres %0d err %0b",
                       o_temp_tenths_c, o_pressure_pa, o_div_error);
                fail_count++;
            end else begin
                t_reading want;
                want = pending_readings.pop_front();
                readings_seen++;
                if (o_div_error) error_readings++;
                if (o_temp_tenths_c !== want.temp) begin
                    $error("temp_tenths_c: expected %0d, got %0d", want.temp, o_temp_tenths_c);
                    fail_count++;
                end
                if (o_pressure_pa !== want.pres) begin
                    $error("pressure_pa: expected %0d, got %0d", want.pres, o_pressure_pa);
                    fail_count++;
                end
                if (o_div_error !== want.err) begin
                    $error("div_error: expected %0b, got %0b", want.err, o_div_error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on total run time.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("barometric_compensation_top_tb failed");
            $finish;
        end
    end

    initial begin
        t_reading  none;
        t_stim_row row;
        none = '{temp: '0, pres: '0, err: 1'b0};
        fail_count = 0;
        items_sent = 0;
        readings_seen = 0;
        error_readings = 0;
        cycle_count = 0;
        idle_pct = 0;
        cal_a = '0;
        cal_b = '0;
        cal_m = '0;
        cal_quad = '0;
        oss_set = '0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_CAL_A;
        i_cfg_data = '0;
        i_raw_temp = '0;
        i_raw_pres_bytes = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. With all-zero calibration the temperature divisor is zero.
        add_sample(16'h0000, 24'h000000, 1, 0, 0, 1);
        add_sample(16'hFFFF, 24'hFFFFFF, 1, 0, 0, 1);
        // Factory example values: 15.0 degC and 69964 Pa.
        add_cfg(REG_CAL_A, {16'd408, 16'hFFB8, 16'hC7D1});
        add_cfg(REG_CAL_B, {16'd32741, 16'd32757, 16'd23153});
        add_cfg(REG_CAL_QUAD, {16'd6190, 16'd4});
        add_cfg(REG_CAL_M, {16'h8000, 16'hDDF9, 16'd2868});
        add_cfg(REG_OSS, 48'd0);
        add_sample(16'd27898, 24'd6103808, 1, 150, 69964, 0);
        add_sample(16'h0000, 24'h000000, 0, 0, 0, 0);
        add_sample(16'hFFFF, 24'hFFFFFF, 0, 0, 0, 0);
        add_sample(16'h8000, 24'h800000, 0, 0, 0, 0);
        add_cfg(REG_OSS, 48'd3);
        add_sample(16'd27898, 24'hFFFFFF, 0, 0, 0, 0);
        add_sample(16'hFFFF, 24'h000000, 0, 0, 0, 0);
        add_sample(16'h5555, 24'hAAAAAA, 0, 0, 0, 0);
        // A zero ac4 makes the pressure divisor zero.
        add_cfg(REG_CAL_B, {16'd0, 16'd32757, 16'd23153});
        add_sample(16'd27898, 24'd6103808, 1, 0, 0, 1);
        add_sample(16'hFFFF, 24'hFFFFFF, 1, 0, 0, 1);
        // Zero ac5 and zero md again give a zero temperature divisor.
        add_cfg(REG_CAL_B, {16'd32741, 16'd0, 16'd23153});
        add_cfg(REG_CAL_M, {16'h7FFF, 16'hDDF9, 16'd0});
        add_sample(16'd27898, 24'd6103808, 1, 0, 0, 1);
        // Extreme coefficients wrap the intermediates.
        add_cfg(REG_CAL_A, 48'h8000_7FFF_8000);
        add_cfg(REG_CAL_B, 48'hFFFF_FFFF_0000);
        add_cfg(REG_CAL_M, 48'h0000_8000_7FFF);
        add_sample(16'hFFFF, 24'hFFFFFF, 0, 0, 0, 0);
        add_sample(16'h0000, 24'h000000, 0, 0, 0, 0);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG) begin
                drain();
                write_reg(row.idx, row.data);
            end else begin
                send_sample(row.raw_temp, row.raw_pres, row.typed, row.want);
            end
        end

        // Random phases, each with its own calibration and an idling rate set by the phase.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            load_calibration(ph);
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 83;
                2: idle_pct = 83;
                default: idle_pct = 10;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == 100) begin
                    start <= 1'b0;
                    @(posedge i_clk);
                    while (pending_readings.size() != 0) @(posedge i_clk);
                end
                if ($urandom_range(3) == 0) begin
                    send_sample(16'($urandom()), 24'($urandom()), 0, none);
                end else begin
                    // Typical sensor ranges.
                    send_sample(16'($urandom_range(24000, 32000)),
                                24'($urandom_range(4000000, 12000000)), 0, none);
                end
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("Sent %0d sample pairs over %0d calibration phases and all oversampling settings.",
                 items_sent, N_PHASES);
        $display("Checked %0d readings, %0d of them with a zero divisor.",
                 readings_seen, error_readings);
        if (fail_count == 0) begin
            $display("barometric_compensation_top_tb passed");
        end else begin
            $display("barometric_compensation_top_tb failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/baro_pkg.sv
rtl/baro_div.sv
rtl/barometric_compensation_top.sv
rtl/baro_checker.sv
verif/barometric_compensation_top_tb.sv
